// ===== hdl/longest_window_bounded_ones_unit_assert.svh =====
// ----------------------------------------------------------------------------
// longest window bounded ones unit - assertion macros
// concurrent checks that fall away to nothing in synthesis
// ----------------------------------------------------------------------------
`ifndef LONGEST_WINDOW_BOUNDED_ONES_UNIT_ASSERT_SVH
`define LONGEST_WINDOW_BOUNDED_ONES_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define LWBO_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("assertion failed");

`define LWBO_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define LWBO_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons)

`define LWBO_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons)

`endif

`endif

// ===== hdl/lwbo_pkg.sv =====
// ----------------------------------------------------------------------------
// lwbo_pkg
// shared widths and the result word type of the window unit
// ----------------------------------------------------------------------------
package lwbo_pkg;

	localparam int TARGET_W    = 13;
	localparam int COUNT_W     = 13;
	localparam int S_TDATA_W   = 8;
	localparam int M_TDATA_W   = 16;

	typedef struct packed {
		logic               impossible;
		logic [COUNT_W-1:0] removed_count;
	} lwbo_result_t;

endpackage

// ===== hdl/longest_window_bounded_ones_unit.sv =====
// ----------------------------------------------------------------------------
// longest_window_bounded_ones_unit
// longest run of elements whose count of ones stays within target_sum
// ----------------------------------------------------------------------------
// Elements arrive one bit per word; a word with tlast closes the sequence and
// yields one result word: the sequence length minus the longest window whose
// count of ones is at most target_sum, with tuser set when the sequence holds
// fewer ones than target_sum. An element goes from idle to the update state
// when nothing leaves the window; otherwise it first passes the drop state,
// which drops front elements one at a time. Each element is dropped at most
// once. The drop rate is set by the single read port of the element memory.
// A closing word waits in its update cycle while the output register still
// holds an untaken result. Elements past MAX_LENGTH are ignored. The memory
// needs no clearing after reset. target_sum is to be written through
// cfg_we/cfg_wdata only while the unit is idle; the unit does not enforce it.
// ----------------------------------------------------------------------------
`include "longest_window_bounded_ones_unit_assert.svh"

module longest_window_bounded_ones_unit
	import lwbo_pkg::*;
#(
	parameter int MAX_LENGTH = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [TARGET_W-1:0]  cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [0] bit_value
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [12:0] removed_count
	output logic [0:0]           m_tuser    // [0] impossible
);

	localparam int AW = $clog2(MAX_LENGTH);

	logic [TARGET_W-1:0] target_q;
	logic                mem_we, mem_wdata, mem_rdata;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic                res_valid, res_ready;
	lwbo_result_t        res;
	lwbo_result_t        out_q;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	lwbo_store #(
		.DEPTH (MAX_LENGTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lwbo_core #(
		.MAX_LENGTH (MAX_LENGTH),
		.AW         (AW)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.target    (target_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_bit    (s_tdata[0]),
		.in_last   (s_tlast),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output word register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = M_TDATA_W'(out_q.removed_count);
	assign m_tuser[0] = out_q.impossible;

	`LWBO_ASSERT_IMP(a_impossible_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[12:0] == 13'd0)
	`LWBO_ASSERT_NXT(a_one_word_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`LWBO_ASSERT_IMP(a_count_in_range, clk, arst_n, m_tvalid, 32'(m_tdata[12:0]) <= 32'(MAX_LENGTH))

endmodule

// ===== hdl/lwbo_store.sv =====
// ----------------------------------------------------------------------------
// lwbo_store
// single bit element memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module lwbo_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/lwbo_core.sv =====
// ----------------------------------------------------------------------------
// lwbo_core
// two pointer window control: stores each element, drops front elements
// through the memory read port and keeps length, sum, best and total counts
// ----------------------------------------------------------------------------
module lwbo_core
	import lwbo_pkg::*;
#(
	parameter int MAX_LENGTH = 4096,
	parameter int AW         = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [TARGET_W-1:0] target,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_bit,
	input  logic                in_last,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output logic                mem_wdata,
	output logic [AW-1:0]       mem_raddr,
	input  logic                mem_rdata,
	output logic                res_valid,
	input  logic                res_ready,
	output lwbo_result_t        res
);

	localparam int CW = $clog2(MAX_LENGTH + 1);
	localparam int SW = ((CW > TARGET_W) ? CW : TARGET_W) + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DROP = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] front_q, back_q, sum_q, best_q, total_q;
	logic          bit_q, last_q, keep_q;

	logic          accept, keep_now, over_now, drop, fits, upd_go, impossible_n;
	logic [CW-1:0] front_inc, back_n, len_n, best_n, back_eff;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign keep_now  = back_q < CW'(MAX_LENGTH);
	assign over_now  = ((SW'(sum_q) + SW'(in_bit)) > SW'(target)) && (front_q < back_q);
	assign drop      = ((SW'(sum_q) + SW'(bit_q)) > SW'(target)) && (front_q < back_q);
	assign front_inc = front_q + CW'(1);

	assign mem_we    = accept && keep_now;
	assign mem_waddr = back_q[AW-1:0];
	assign mem_wdata = in_bit;
	assign mem_raddr = (state_q == ST_DROP) ? front_inc[AW-1:0] : front_q[AW-1:0];

	// window update once the front is trimmed
	assign fits     = (SW'(sum_q) + SW'(bit_q)) <= SW'(target);
	assign back_n   = back_q + CW'(1);
	assign len_n    = back_n - front_q;
	assign best_n   = (keep_q && fits && (len_n > best_q)) ? len_n : best_q;
	assign back_eff = keep_q ? back_n : back_q;

	assign impossible_n      = SW'(total_q) < SW'(target);
	assign res.impossible    = impossible_n;
	assign res.removed_count = impossible_n ? '0 : COUNT_W'(back_eff - best_n);
	assign res_valid         = (state_q == ST_UPD) && last_q;
	assign upd_go            = (state_q == ST_UPD) && (!last_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			back_q  <= '0;
			sum_q   <= '0;
			best_q  <= '0;
			total_q <= '0;
			bit_q   <= 1'b0;
			last_q  <= 1'b0;
			keep_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bit_q  <= in_bit;
						last_q <= in_last;
						keep_q <= keep_now;
						if (keep_now) begin
							total_q <= total_q + CW'(in_bit);
						end
						state_q <= (keep_now && over_now) ? ST_DROP : ST_UPD;
					end
				end
				ST_DROP: begin
					if (drop) begin
						sum_q   <= sum_q - CW'(mem_rdata);
						front_q <= front_inc;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (upd_go) begin
						if (last_q) begin
							front_q <= '0;
							back_q  <= '0;
							sum_q   <= '0;
							best_q  <= '0;
							total_q <= '0;
						end else if (keep_q) begin
							back_q <= back_n;
							if (fits) begin
								sum_q  <= sum_q + CW'(bit_q);
								best_q <= best_n;
							end else begin
								front_q <= back_n;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
